[rtl/core/pdc_pkg.sv]
// Shared types and constants for the PWM dead-time compensation block.
package pdc_pkg;

    localparam int CMP_W   = 16;
    localparam int CUR_W   = 16;
    localparam int DEAD_W  = 12;
    localparam int GAIN_W  = 10;
    localparam int BAND_W  = 15;
    localparam int DG_W    = DEAD_W + GAIN_W;
    localparam int DFRAC_W = 4;
    localparam int GFRAC_W = 8;
    localparam int CFG_W   = 16;
    localparam int PHASES  = 3;

    localparam logic [GAIN_W-1:0] GAIN_MAX = 10'd512;

    localparam logic              RST_ENABLE = 1'b1;
    localparam logic [DEAD_W-1:0] RST_DEAD   = 12'd800;
    localparam logic [GAIN_W-1:0] RST_GAIN   = 10'd205;
    localparam logic [BAND_W-1:0] RST_BAND   = 15'd50;
    localparam logic [CMP_W-1:0]  RST_FLOOR  = 16'd1;
    localparam logic [CMP_W-1:0]  RST_CEIL   = 16'd6999;
    localparam logic [DG_W-1:0]   RST_DG     = 22'd164000;

    typedef enum logic [2:0] {
        CFG_ENABLE = 3'd0,
        CFG_DEAD   = 3'd1,
        CFG_GAIN   = 3'd2,
        CFG_BAND   = 3'd3,
        CFG_FLOOR  = 3'd4,
        CFG_CEIL   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [CUR_W-1:0] current_u;
        logic signed [CUR_W-1:0] current_v;
        logic signed [CUR_W-1:0] current_w;
        logic [CMP_W-1:0]        compare_u;
        logic [CMP_W-1:0]        compare_v;
        logic [CMP_W-1:0]        compare_w;
    } in_t;

    typedef struct packed {
        logic [CMP_W-1:0] adjusted_u;
        logic [CMP_W-1:0] adjusted_v;
        logic [CMP_W-1:0] adjusted_w;
    } out_t;

    // settings as seen by the datapath
    typedef struct packed {
        logic              enable;
        logic [BAND_W-1:0] band;
        logic [CMP_W-1:0]  floor_val;
        logic [CMP_W-1:0]  ceil_eff;
        logic [DG_W-1:0]   dead_gain;
    } cfg_t;

endpackage

[rtl/core/pdc_cfg_regs.sv]
// Configuration registers and precomputed dead-time times gain product.
module pdc_cfg_regs
    import pdc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  cfg_index_t       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output cfg_t             cfg
);

    logic              enable_reg;
    logic [DEAD_W-1:0] dead_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [BAND_W-1:0] band_reg;
    logic [CMP_W-1:0]  floor_reg;
    logic [CMP_W-1:0]  ceil_reg;
    logic [DG_W-1:0]   dg_reg;
    logic [DG_W-1:0]   dg_next;
    logic [CMP_W-1:0]  ceil_eff_reg;
    logic [CMP_W-1:0]  ceil_eff_next;
    logic [GAIN_W-1:0] gain_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= RST_ENABLE;
            dead_reg   <= RST_DEAD;
            gain_reg   <= RST_GAIN;
            band_reg   <= RST_BAND;
            floor_reg  <= RST_FLOOR;
            ceil_reg   <= RST_CEIL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE: enable_reg <= cfg_data[0];
                CFG_DEAD:   dead_reg   <= cfg_data[DEAD_W-1:0];
                CFG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_BAND:   band_reg   <= cfg_data[BAND_W-1:0];
                CFG_FLOOR:  floor_reg  <= cfg_data;
                CFG_CEIL:   ceil_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // gain saturates at 2.0; ceiling never below floor
    always_comb
    begin
        gain_eff      = (gain_reg > GAIN_MAX) ? GAIN_MAX : gain_reg;
        dg_next       = DG_W'(dead_reg) * DG_W'(gain_eff);
        ceil_eff_next = (ceil_reg < floor_reg) ? floor_reg : ceil_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dg_reg       <= RST_DG;
            ceil_eff_reg <= RST_CEIL;
        end
        else
        begin
            dg_reg       <= dg_next;
            ceil_eff_reg <= ceil_eff_next;
        end
    end

    assign cfg.enable    = enable_reg;
    assign cfg.band      = band_reg;
    assign cfg.floor_val = floor_reg;
    assign cfg.ceil_eff  = ceil_eff_reg;
    assign cfg.dead_gain = dg_reg;

endmodule

[rtl/core/pdc_weight.sv]
// Current magnitude and pipelined restoring divider producing per-phase weights.
module pdc_weight
    import pdc_pkg::*;
#(
    parameter int W = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  in_t                           in_data,
    input  logic [BAND_W-1:0]             band,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [PHASES-1:0][W:0]        weight,
    output logic [PHASES-1:0]             neg,
    output logic [PHASES-1:0][CMP_W-1:0]  cmp
);

    // stage 0 takes magnitudes, stages 1..W each resolve one quotient bit
    localparam int NS = W + 1;
    localparam logic [W:0] ONE = {1'b1, {W{1'b0}}};

    logic [NS:0]                         rdy;
    logic [NS-1:0]                       v_reg;
    logic [PHASES-1:0][CMP_W-1:0]        cmp_reg  [NS];
    logic [PHASES-1:0]                   neg_reg  [NS];
    logic [PHASES-1:0]                   zero_reg [NS];
    logic [PHASES-1:0]                   full_reg [NS];
    logic [PHASES-1:0][BAND_W-1:0]       rem_reg  [NS];
    logic [PHASES-1:0][W-1:0]            q_reg    [NS];

    logic [PHASES-1:0][CUR_W-1:0]        cur_in;
    logic [PHASES-1:0][CMP_W-1:0]        cmp_in;
    logic [PHASES-1:0][CUR_W-1:0]        mag0;
    logic [PHASES-1:0]                   neg0;
    logic [PHASES-1:0]                   zero0;
    logic [PHASES-1:0]                   full0;

    assign cur_in[0] = in_data.current_u;
    assign cur_in[1] = in_data.current_v;
    assign cur_in[2] = in_data.current_w;
    assign cmp_in[0] = in_data.compare_u;
    assign cmp_in[1] = in_data.compare_v;
    assign cmp_in[2] = in_data.compare_w;

    assign rdy[NS] = out_ready;

    // most negative current gives magnitude 0x8000, which still fits
    always_comb
    begin
        for (int p = 0; p < PHASES; p++)
        begin
            neg0[p]  = cur_in[p][CUR_W-1];
            mag0[p]  = neg0[p] ? CUR_W'(~cur_in[p] + 1'b1) : cur_in[p];
            zero0[p] = (mag0[p] == '0);
            full0[p] = (band == '0) || (mag0[p] >= CUR_W'(band));
        end
    end

    assign rdy[0] = !v_reg[0] || rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (rdy[0])
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            for (int p = 0; p < PHASES; p++)
            begin
                cmp_reg[0][p]  <= cmp_in[p];
                neg_reg[0][p]  <= neg0[p];
                zero_reg[0][p] <= zero0[p];
                full_reg[0][p] <= full0[p];
                rem_reg[0][p]  <= mag0[p][BAND_W-1:0];
                q_reg[0][p]    <= '0;
            end
        end
    end

    for (genvar s = 1; s < NS; s++)
    begin : g_div
        logic [PHASES-1:0][BAND_W:0]   sh;
        logic [PHASES-1:0]             ge;
        logic [PHASES-1:0][BAND_W-1:0] rem_n;
        logic [PHASES-1:0][W-1:0]      q_n;

        // remainder stays below band, so the shifted value fits 16 bits
        always_comb
        begin
            for (int p = 0; p < PHASES; p++)
            begin
                sh[p]    = {rem_reg[s-1][p], 1'b0};
                ge[p]    = sh[p] >= {1'b0, band};
                rem_n[p] = ge[p] ? BAND_W'(sh[p] - {1'b0, band}) : sh[p][BAND_W-1:0];
                q_n[p]   = {q_reg[s-1][p][W-2:0], ge[p]};
            end
        end

        assign rdy[s] = !v_reg[s] || rdy[s+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (rdy[s])
                v_reg[s] <= v_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s] && v_reg[s-1])
            begin
                cmp_reg[s]  <= cmp_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
                full_reg[s] <= full_reg[s-1];
                rem_reg[s]  <= rem_n;
                q_reg[s]    <= q_n;
            end
        end
    end

    always_comb
    begin
        for (int p = 0; p < PHASES; p++)
        begin
            if (zero_reg[NS-1][p])
                weight[p] = '0;
            else if (full_reg[NS-1][p])
                weight[p] = ONE;
            else
                weight[p] = {1'b0, q_reg[NS-1][p]};
        end
    end

    assign neg       = neg_reg[NS-1];
    assign cmp       = cmp_reg[NS-1];
    assign out_valid = v_reg[NS-1];
    assign in_ready  = rdy[0];

endmodule

[rtl/core/pdc_apply.sv]
// Offset multiply, add, clamp and round stages with the output register.
module pdc_apply
    import pdc_pkg::*;
#(
    parameter int W = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [PHASES-1:0][W:0]        weight,
    input  logic [PHASES-1:0]             neg,
    input  logic [PHASES-1:0][CMP_W-1:0]  cmp,
    input  cfg_t                          cfg,
    output logic                          out_valid,
    input  logic                          out_ready,
    output out_t                          out_data
);

    localparam int T  = DFRAC_W + GFRAC_W + W;   // fraction bits of the offset
    localparam int PW = DG_W + W + 1;
    // a full-scale compare plus the largest offset needs one bit above the compare
    localparam int VW = CMP_W + T + 2;
    localparam int NS = 4;

    logic [NS:0]   rdy;
    logic [NS-1:0] v_reg;

    // stage 0: offset magnitude
    logic [PHASES-1:0][PW-1:0]     prod_reg;
    logic [PHASES-1:0][PW-1:0]     prod_next;
    logic [PHASES-1:0]             neg0_reg;
    logic [PHASES-1:0][CMP_W-1:0]  cmp0_reg;
    // stage 1: signed sum
    logic [PHASES-1:0][VW-1:0]     val_reg;
    logic [PHASES-1:0][VW-1:0]     val_next;
    logic [PHASES-1:0][CMP_W-1:0]  cmp1_reg;
    // stage 2: window compare
    logic [PHASES-1:0]             lt_reg;
    logic [PHASES-1:0]             lt_next;
    logic [PHASES-1:0]             gt_reg;
    logic [PHASES-1:0]             gt_next;
    logic [PHASES-1:0][CMP_W-1:0]  whole_reg;
    logic [PHASES-1:0]             half_reg;
    logic [PHASES-1:0][CMP_W-1:0]  cmp2_reg;
    // stage 3: output
    logic [PHASES-1:0][CMP_W-1:0]  res_reg;
    logic [PHASES-1:0][CMP_W-1:0]  res_next;

    logic [VW-1:0] lo;
    logic [VW-1:0] hi;

    assign rdy[NS] = out_ready;
    for (genvar s = 0; s < NS; s++)
    begin : g_rdy
        assign rdy[s] = !v_reg[s] || rdy[s+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++)
            begin
                if (rdy[s])
                    v_reg[s] <= v_reg[s-1];
            end
        end
    end

    assign lo = {2'b0, cfg.floor_val, {T{1'b0}}};
    assign hi = {2'b0, cfg.ceil_eff, {T{1'b0}}};

    always_comb
    begin
        for (int p = 0; p < PHASES; p++)
        begin
            prod_next[p] = PW'(cfg.dead_gain) * PW'(weight[p]);
            val_next[p]  = {2'b0, cmp0_reg[p], {T{1'b0}}}
                         + (neg0_reg[p] ? VW'(~VW'(prod_reg[p]) + 1'b1) : VW'(prod_reg[p]));
            lt_next[p]   = $signed(val_reg[p]) < $signed(lo);
            gt_next[p]   = $signed(val_reg[p]) > $signed(hi);
            // inside the window the rounded value cannot pass the ceiling
            if (!cfg.enable)
                res_next[p] = cmp2_reg[p];
            else if (lt_reg[p])
                res_next[p] = cfg.floor_val;
            else if (gt_reg[p])
                res_next[p] = cfg.ceil_eff;
            else
                res_next[p] = whole_reg[p] + CMP_W'(half_reg[p]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            prod_reg <= prod_next;
            neg0_reg <= neg;
            cmp0_reg <= cmp;
        end
        if (rdy[1] && v_reg[0])
        begin
            val_reg  <= val_next;
            cmp1_reg <= cmp0_reg;
        end
        if (rdy[2] && v_reg[1])
        begin
            lt_reg   <= lt_next;
            gt_reg   <= gt_next;
            cmp2_reg <= cmp1_reg;
            for (int p = 0; p < PHASES; p++)
            begin
                whole_reg[p] <= val_reg[p][T+CMP_W-1:T];
                half_reg[p]  <= val_reg[p][T-1];
            end
        end
        if (rdy[3] && v_reg[2])
            res_reg <= res_next;
    end

    assign in_ready            = rdy[0];
    assign out_valid           = v_reg[NS-1];
    assign out_data.adjusted_u = res_reg[0];
    assign out_data.adjusted_v = res_reg[1];
    assign out_data.adjusted_w = res_reg[2];

endmodule

[rtl/core/pwm_deadtime_compensation.sv]
// Three-phase PWM dead-time compensation, top level.
// Throughput: one word per cycle while out_ready stays high;
// the weight divider is a pipeline of one stage per bit.
// Stalls back up stage by stage; bubbles are filled while the output word waits.
// Reset: settings return to their defaults, the pipeline empties.
module pwm_deadtime_compensation
    import pdc_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_t             out_data,
    input  logic             cfg_we,
    input  cfg_index_t       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int W = WEIGHT_FRAC_BITS;

    cfg_t                         cfg;
    logic                         wt_valid;
    logic                         wt_ready;
    logic [PHASES-1:0][W:0]       wt;
    logic [PHASES-1:0]            wt_neg;
    logic [PHASES-1:0][CMP_W-1:0] wt_cmp;

    pdc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdc_weight #(.W(W)) u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .band      (cfg.band),
        .out_valid (wt_valid),
        .out_ready (wt_ready),
        .weight    (wt),
        .neg       (wt_neg),
        .cmp       (wt_cmp)
    );

    pdc_apply #(.W(W)) u_apply (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (wt_valid),
        .in_ready  (wt_ready),
        .weight    (wt),
        .neg       (wt_neg),
        .cmp       (wt_cmp),
        .cfg       (cfg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
